FILE: design/arq_retransmit_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// ARQ retransmit controller assertion macros
// Shared concurrent assertion forms for the ARQ controller modules.
// ----------------------------------------------------------------------------
`ifndef ARQ_RETRANSMIT_CONTROLLER_UNIT_MACROS_SVH
`define ARQ_RETRANSMIT_CONTROLLER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/arq_pkg.sv
// ----------------------------------------------------------------------------
// ARQ package
// Types, codes and reset constants shared by the ARQ controller modules.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int SLOT_COUNT_DEF = 8;

    localparam logic [15:0] ACK_TIMEOUT_RST      = 16'd500;
    localparam logic [15:0] SLOW_TIMEOUT_RST     = 16'd5000;
    localparam logic [7:0]  FAST_RETRY_LIMIT_RST = 8'd5;
    localparam logic [15:0] POLL_INTERVAL_RST    = 16'd50;
    localparam logic [15:0] NEXT_ID_RST          = 16'd1;
    localparam logic [7:0]  RETRY_MAX            = 8'hFF;

    typedef enum logic [1:0] {
        REQ_ENQUEUE,
        REQ_ACK,
        REQ_DATA,
        REQ_TICK
    } t_req;

    typedef enum logic [1:0] {
        CFG_ACK_TIMEOUT,
        CFG_SLOW_TIMEOUT,
        CFG_FAST_RETRY_LIMIT,
        CFG_POLL_INTERVAL
    } t_cfg_index;

    typedef enum logic [2:0] {
        KIND_QUEUED,
        KIND_FULL,
        KIND_TX_DATA,
        KIND_TX_ACK,
        KIND_DELIVER,
        KIND_ACK_MATCH,
        KIND_ACK_UNMATCH
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  slot;
        logic [15:0] id;
        logic [7:0]  retry;
    } t_result;

    typedef struct packed {
        logic push;
        logic flush;
    } t_out_ctrl;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  retries;
        logic [31:0] send_time;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_DATA,
        S_DATA_ACK,
        S_POLL,
        S_SEND,
        S_RD0,
        S_SCAN,
        S_FLUSH
    } t_state;

endpackage

FILE: design/arq_ram.sv
// ----------------------------------------------------------------------------
// ARQ slot RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module arq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/arq_out_stage.sv
// ----------------------------------------------------------------------------
// ARQ output stage
// Holds each result back by one so that the final beat of an item is marked.
// ----------------------------------------------------------------------------
`include "arq_retransmit_controller_unit_macros.svh"

module arq_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arq_pkg::t_out_ctrl i_ctrl,
    input  arq_pkg::t_result   i_result,
    output logic               o_strobe,
    output arq_pkg::t_result   o_result,
    output logic               o_last
);

    import arq_pkg::*;

    logic    r_pend_valid;
    t_result r_pend;
    logic    r_strobe;
    t_result r_out;
    logic    r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_strobe <= (i_ctrl.push || i_ctrl.flush) && r_pend_valid;
            if (i_ctrl.push) begin
                r_pend       <= i_result;
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out  <= r_pend;
                    r_last <= 1'b0;
                end
            end else if (i_ctrl.flush) begin
                r_pend_valid <= 1'b0;
                if (r_pend_valid) begin
                    r_out  <= r_pend;
                    r_last <= 1'b1;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;
    assign o_last   = r_last;

    `ARQ_ASSERT_SAME(a_flush_without_push, i_clk, i_rst_n, i_ctrl.flush, !i_ctrl.push, "Flush with push.")
    `ARQ_ASSERT_NEXT(a_push_holds_pending, i_clk, i_rst_n, i_ctrl.push, r_pend_valid, "Push lost.")
    `ARQ_ASSERT_NEXT(a_flush_drains, i_clk, i_rst_n, i_ctrl.flush, !r_pend_valid, "Flush kept beat.")

endmodule

FILE: design/arq_retransmit_controller_unit.sv
// ----------------------------------------------------------------------------
// ARQ retransmit controller
// Sending side of an acknowledged link: slot table, ack matching, duplicate
// filtering of received data and timed first sends and retransmissions.
// ----------------------------------------------------------------------------
// One slot table memory read per cycle.
// A result beat is held until the next beat of its item is made or the item
// ends, so the final beat shows in the first cycle in which busy is low.
// A new item is taken in any cycle in which busy is low.
// Synchronous active-low reset clears slot flags and reloads ids and registers.
`include "arq_retransmit_controller_unit_macros.svh"

module arq_retransmit_controller_unit #(
    parameter int SLOT_COUNT = arq_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_packet_id,
    input  logic [31:0] i_now_time,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic [2:0]  o_result_kind,
    output logic [2:0]  o_slot_index,
    output logic [15:0] o_result_id,
    output logic [7:0]  o_retry_count,
    output logic        o_last_result
);

    import arq_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    function automatic logic [2:0] slot_code(input logic [SW-1:0] s);
        logic [SW+2:0] w;
        w = {3'b000, s};
        return w[2:0];
    endfunction

    t_state r_state, n_state;

    logic [15:0] r_ack_timeout;
    logic [15:0] r_slow_timeout;
    logic [7:0]  r_fast_retry_limit;
    logic [15:0] r_poll_interval;

    logic [SLOT_COUNT-1:0] r_used;
    logic [SLOT_COUNT-1:0] r_sent;
    logic [15:0] r_next_id;
    logic [15:0] r_last_rx;
    logic [31:0] r_last_poll;

    t_req        r_req;
    logic [15:0] r_pid;
    logic [31:0] r_now;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_send_slot;

    logic          free_found, used_found;
    logic [SW-1:0] free_slot, used_slot;

    logic          ram_we, ram_re;
    logic [SW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ent;

    t_out_ctrl out_ctrl;
    t_result   out_res, stage_res;

    logic [31:0] elapsed;
    logic [15:0] limit;
    logic [7:0]  retry_inc;
    logic        expired, match, poll_due, send_first, data_new, scan_end;

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        used_found = 1'b0;
        used_slot  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
            if (r_used[i]) begin
                used_found = 1'b1;
                used_slot  = SW'(i);
            end
        end
    end

    assign elapsed    = r_now - ent.send_time;
    assign limit      = (ent.retries < r_fast_retry_limit) ? r_ack_timeout : r_slow_timeout;
    assign retry_inc  = (ent.retries == RETRY_MAX) ? ent.retries : ent.retries + 8'd1;
    assign expired    = r_used[r_idx] && r_sent[r_idx] && (elapsed >= {16'd0, limit});
    assign match      = r_used[r_idx] && (ent.id == r_pid);
    assign poll_due   = (r_now - r_last_poll) > {16'd0, r_poll_interval};
    assign send_first = poll_due && used_found && !r_sent[used_slot];
    assign data_new   = r_pid != r_last_rx;
    assign scan_end   = (r_idx == LAST_SLOT) || ((r_req == REQ_ACK) && match);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_req'(i_req_type))
                        REQ_ENQUEUE: n_state = S_ENQ;
                        REQ_ACK:     n_state = S_RD0;
                        REQ_DATA:    n_state = S_DATA;
                        REQ_TICK:    n_state = S_POLL;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_ENQ:      n_state = S_FLUSH;
            S_DATA:     n_state = data_new ? S_DATA_ACK : S_FLUSH;
            S_DATA_ACK: n_state = S_FLUSH;
            S_POLL:     n_state = send_first ? S_SEND : S_RD0;
            S_SEND:     n_state = S_RD0;
            S_RD0:      n_state = S_SCAN;
            S_SCAN:     n_state = scan_end ? S_FLUSH : S_SCAN;
            S_FLUSH:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '{id: ent.id, retries: ent.retries, send_time: r_now};
        ram_re    = 1'b0;
        ram_raddr = '0;
        out_ctrl  = '{push: 1'b0, flush: 1'b0};
        out_res   = '{kind: KIND_QUEUED, slot: 3'd0, id: 16'd0, retry: 8'd0};
        case (r_state)
            S_ENQ: begin
                out_ctrl.push = 1'b1;
                if (free_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = free_slot;
                    ram_wdata = '{id: r_next_id, retries: 8'd0, send_time: 32'd0};
                    out_res   = '{kind: KIND_QUEUED, slot: slot_code(free_slot),
                                  id: r_next_id, retry: 8'd0};
                end else begin
                    out_res.kind = KIND_FULL;
                end
            end
            S_DATA: begin
                out_ctrl.push = 1'b1;
                out_res.kind  = data_new ? KIND_DELIVER : KIND_TX_ACK;
                out_res.id    = r_pid;
            end
            S_DATA_ACK: begin
                out_ctrl.push = 1'b1;
                out_res.kind  = KIND_TX_ACK;
                out_res.id    = r_pid;
            end
            S_POLL: begin
                ram_re    = send_first;
                ram_raddr = used_slot;
            end
            S_SEND: begin
                ram_we        = 1'b1;
                ram_waddr     = r_send_slot;
                out_ctrl.push = 1'b1;
                out_res       = '{kind: KIND_TX_DATA, slot: slot_code(r_send_slot),
                                  id: ent.id, retry: ent.retries};
            end
            S_RD0: begin
                ram_re = 1'b1;
            end
            S_SCAN: begin
                if (!scan_end) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx + SW'(1);
                end
                if (r_req == REQ_ACK) begin
                    if (match) begin
                        out_ctrl.push = 1'b1;
                        out_res = '{kind: KIND_ACK_MATCH, slot: slot_code(r_idx),
                                    id: r_pid, retry: 8'd0};
                    end else if (scan_end) begin
                        out_ctrl.push = 1'b1;
                        out_res = '{kind: KIND_ACK_UNMATCH, slot: 3'd0,
                                    id: r_pid, retry: 8'd0};
                    end
                end else if (expired) begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_idx;
                    ram_wdata     = '{id: ent.id, retries: retry_inc, send_time: r_now};
                    out_ctrl.push = 1'b1;
                    out_res       = '{kind: KIND_TX_DATA, slot: slot_code(r_idx),
                                      id: ent.id, retry: retry_inc};
                end
            end
            S_FLUSH: begin
                out_ctrl.flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_ack_timeout      <= ACK_TIMEOUT_RST;
            r_slow_timeout     <= SLOW_TIMEOUT_RST;
            r_fast_retry_limit <= FAST_RETRY_LIMIT_RST;
            r_poll_interval    <= POLL_INTERVAL_RST;
            r_used             <= '0;
            r_sent             <= '0;
            r_next_id          <= NEXT_ID_RST;
            r_last_rx          <= 16'd0;
            r_last_poll        <= 32'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ACK_TIMEOUT:      r_ack_timeout      <= i_cfg_data;
                    CFG_SLOW_TIMEOUT:     r_slow_timeout     <= i_cfg_data;
                    CFG_FAST_RETRY_LIMIT: r_fast_retry_limit <= i_cfg_data[7:0];
                    CFG_POLL_INTERVAL:    r_poll_interval    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_ENQ: begin
                    if (free_found) begin
                        r_used[free_slot] <= 1'b1;
                        r_sent[free_slot] <= 1'b0;
                        r_next_id         <= r_next_id + 16'd1;
                    end
                end
                S_DATA: begin
                    if (data_new) begin
                        r_last_rx <= r_pid;
                    end
                end
                S_POLL: begin
                    if (poll_due) begin
                        r_last_poll <= r_now;
                    end
                end
                S_SEND: begin
                    r_sent[r_send_slot] <= 1'b1;
                end
                S_SCAN: begin
                    if ((r_req == REQ_ACK) && match) begin
                        r_used[r_idx] <= 1'b0;
                        r_sent[r_idx] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_req <= t_req'(i_req_type);
            r_pid <= i_packet_id;
            r_now <= i_now_time;
        end
        if (r_state == S_POLL) begin
            r_send_slot <= used_slot;
        end
        if (r_state == S_RD0) begin
            r_idx <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + SW'(1);
        end
    end

    arq_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(SLOT_COUNT),
        .AW   (SW)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ent)
    );

    arq_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (out_ctrl),
        .i_result(out_res),
        .o_strobe(o_result_strobe),
        .o_result(stage_res),
        .o_last  (o_last_result)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_result_kind = stage_res.kind;
    assign o_slot_index  = stage_res.slot;
    assign o_result_id   = stage_res.id;
    assign o_retry_count = stage_res.retry;

    `ARQ_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy, "Not busy.")
    `ARQ_ASSERT_SAME(a_ram_no_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "Clash.")
    `ARQ_ASSERT_SAME(a_nonfinal_while_busy, i_clk, i_rst_n, o_result_strobe && !o_last_result, busy, "Late.")

endmodule

FILE: test/arq_retransmit_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARQ retransmit controller testbench
// Drives enqueue, ack, data and tick commands through the start/busy port and
// checks every result beat against a cycle-free model of the slot table. The
// run covers directed corner cases, random traffic under several register
// settings (zero and maximum timeouts among them) and retry saturation.
// ----------------------------------------------------------------------------
module arq_retransmit_controller_unit_tb;
    import arq_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    typedef struct packed {
        t_req        req;
        logic [15:0] pid;
        logic [31:0] now;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  slot;
        logic [15:0] id;
        logic [7:0]  retry;
        logic        last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = REQ_ENQUEUE;
    logic [15:0] i_packet_id = 16'h0000;
    logic [31:0] i_now_time = 32'h0000_0000;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_ACK_TIMEOUT;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        o_result_strobe;
    logic [2:0]  o_result_kind;
    logic [2:0]  o_slot_index;
    logic [15:0] o_result_id;
    logic [7:0]  o_retry_count;
    logic        o_last_result;

    t_cmd  pending_cmds[$];
    t_beat awaited_results[$];
    t_cmd  drv_cmd;
    t_beat held_beat;
    bit    beat_held = 1'b0;
    int    idle_pct = 15;
    int    fault_count = 0;
    logic [31:0] now_cursor = 32'h0000_0000;

    // Shadow of the slot table and registers.
    bit          tbl_used[SLOTS];
    bit          tbl_sent[SLOTS];
    logic [15:0] tbl_id[SLOTS];
    logic [7:0]  tbl_retries[SLOTS];
    logic [31:0] tbl_sent_at[SLOTS];
    logic [15:0] id_next = NEXT_ID_RST;
    logic [15:0] rx_last = 16'h0000;
    logic [31:0] poll_last = 32'h0000_0000;
    logic [15:0] cfg_ack_to = ACK_TIMEOUT_RST;
    logic [15:0] cfg_slow_to = SLOW_TIMEOUT_RST;
    logic [7:0]  cfg_fast_lim = FAST_RETRY_LIMIT_RST;
    logic [15:0] cfg_poll = POLL_INTERVAL_RST;

    arq_retransmit_controller_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_packet_id     (i_packet_id),
        .i_now_time      (i_now_time),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result_kind   (o_result_kind),
        .o_slot_index    (o_slot_index),
        .o_result_id     (o_result_id),
        .o_retry_count   (o_retry_count),
        .o_last_result   (o_last_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void stage_beat(t_kind kind, logic [2:0] slot, logic [15:0] pkt,
                                       logic [7:0] retry);
        if (beat_held)
            awaited_results.push_back(held_beat);
        held_beat = '{kind: kind, slot: slot, id: pkt, retry: retry, last: 1'b0};
        beat_held = 1'b1;
    endfunction

    function automatic void send_slot(int s, logic [31:0] now);
        tbl_sent[s] = 1'b1;
        tbl_sent_at[s] = now;
        stage_beat(KIND_TX_DATA, 3'(s), tbl_id[s], tbl_retries[s]);
    endfunction

    function automatic void compute_results(t_req req, logic [15:0] pid, logic [31:0] now);
        int hit;
        int s;
        logic [31:0] limit;
        hit = -1;
        case (req)
            REQ_ENQUEUE: begin
                for (s = 0; s < SLOTS; s++)
                    if (hit < 0 && !tbl_used[s])
                        hit = s;
                if (hit >= 0) begin
                    tbl_used[hit] = 1'b1;
                    tbl_sent[hit] = 1'b0;
                    tbl_retries[hit] = 8'd0;
                    tbl_sent_at[hit] = 32'd0;
                    tbl_id[hit] = id_next;
                    id_next = id_next + 16'd1;
                    stage_beat(KIND_QUEUED, 3'(hit), tbl_id[hit], 8'd0);
                end else begin
                    stage_beat(KIND_FULL, 3'd0, 16'd0, 8'd0);
                end
            end
            REQ_ACK: begin
                for (s = 0; s < SLOTS; s++)
                    if (hit < 0 && tbl_used[s] && tbl_id[s] == pid)
                        hit = s;
                if (hit >= 0) begin
                    tbl_used[hit] = 1'b0;
                    tbl_sent[hit] = 1'b0;
                    stage_beat(KIND_ACK_MATCH, 3'(hit), pid, 8'd0);
                end else begin
                    stage_beat(KIND_ACK_UNMATCH, 3'd0, pid, 8'd0);
                end
            end
            REQ_DATA: begin
                if (pid != rx_last) begin
                    rx_last = pid;
                    stage_beat(KIND_DELIVER, 3'd0, pid, 8'd0);
                end
                stage_beat(KIND_TX_ACK, 3'd0, pid, 8'd0);
            end
            default: begin
                if (now - poll_last > cfg_poll) begin
                    poll_last = now;
                    for (s = 0; s < SLOTS; s++)
                        if (hit < 0 && tbl_used[s])
                            hit = s;
                    if (hit >= 0 && !tbl_sent[hit])
                        send_slot(hit, now);
                end
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_used[s] && tbl_sent[s]) begin
                        limit = (tbl_retries[s] < cfg_fast_lim) ? cfg_ack_to : cfg_slow_to;
                        if (now - tbl_sent_at[s] >= limit) begin
                            if (tbl_retries[s] != RETRY_MAX)
                                tbl_retries[s] = tbl_retries[s] + 8'd1;
                            send_slot(s, now);
                        end
                    end
                end
            end
        endcase
        if (beat_held) begin
            held_beat.last = 1'b1;
            awaited_results.push_back(held_beat);
            beat_held = 1'b0;
        end
    endfunction

    function automatic void held_check(t_beat want);
        if (o_result_kind !== want.kind || o_slot_index !== want.slot
            || o_result_id !== want.id || o_retry_count !== want.retry
            || o_last_result !== want.last) begin
            fault_count++;
            $display({"%0t: beat mismatch: expected kind %0d slot %0d id %h retry %0d ",
                      "last %0d, actual kind %0d slot %0d id %h retry %0d last %0d"},
                     $time, want.kind, want.slot, want.id, want.retry, want.last,
                     o_result_kind, o_slot_index, o_result_id, o_retry_count,
                     o_last_result);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                compute_results(t_req'(i_req_type), i_packet_id, i_now_time);
            if (!start || !busy) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    drv_cmd = pending_cmds.pop_front();
                    start <= 1'b1;
                    i_req_type <= drv_cmd.req;
                    i_packet_id <= drv_cmd.pid;
                    i_now_time <= drv_cmd.now;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe !== 1'b0) begin
            if (awaited_results.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected beat: kind %0d slot %0d id %h retry %0d last %0d",
                         $time, o_result_kind, o_slot_index, o_result_id, o_retry_count,
                         o_last_result);
            end else begin
                held_check(awaited_results.pop_front());
            end
        end
    end

    task automatic queue_cmd(t_req req, logic [15:0] pid, logic [31:0] now);
        while (pending_cmds.size() >= 2)
            @(posedge i_clk);
        pending_cmds.push_back('{req: req, pid: pid, now: now});
    endtask

    function automatic logic [31:0] next_now(int step_max);
        if ($urandom_range(19) == 0)
            now_cursor = $urandom;
        else
            now_cursor = now_cursor + $urandom_range(step_max);
        return now_cursor;
    endfunction

    function automatic logic [15:0] ack_guess();
        logic [15:0] open_ids[$];
        int s;
        for (s = 0; s < SLOTS; s++)
            if (tbl_used[s])
                open_ids.push_back(tbl_id[s]);
        if (open_ids.size() != 0 && $urandom_range(9) < 7)
            return open_ids[$urandom_range(open_ids.size() - 1)];
        return 16'($urandom);
    endfunction

    task automatic random_items(int count, int step_max);
        int n;
        int roll;
        t_req req;
        logic [15:0] pid;
        logic [31:0] now;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            pid = 16'($urandom);
            now = $urandom;
            if (roll < 25) begin
                req = REQ_ENQUEUE;
            end else if (roll < 50) begin
                req = REQ_ACK;
                pid = ack_guess();
            end else if (roll < 68) begin
                req = REQ_DATA;
                if ($urandom_range(1) == 0)
                    pid = rx_last;
            end else begin
                req = REQ_TICK;
                now = next_now(step_max);
            end
            queue_cmd(req, pid, now);
        end
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || awaited_results.size() != 0 || busy);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] ack_to, logic [15:0] slow_to,
                                logic [7:0] fast_lim, logic [15:0] poll);
        t_cfg_index idx[4];
        logic [15:0] vals[4];
        int k;
        idx = '{CFG_ACK_TIMEOUT, CFG_SLOW_TIMEOUT, CFG_FAST_RETRY_LIMIT, CFG_POLL_INTERVAL};
        vals = '{ack_to, slow_to, {8'($urandom), fast_lim}, poll};
        for (k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_ack_to = ack_to;
        cfg_slow_to = slow_to;
        cfg_fast_lim = fast_lim;
        cfg_poll = poll;
    endtask

    initial begin
        int k;
        for (k = 0; k < SLOTS; k++) begin
            tbl_used[k] = 1'b0;
            tbl_sent[k] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases under the reset register values.
        idle_pct = 15;
        queue_cmd(REQ_DATA, 16'h0000, $urandom);
        queue_cmd(REQ_DATA, 16'hFFFF, $urandom);
        queue_cmd(REQ_DATA, 16'hFFFF, $urandom);
        queue_cmd(REQ_ACK, 16'h1234, $urandom);
        queue_cmd(REQ_TICK, 16'($urandom), 32'h0000_0000);
        repeat (SLOTS + 1) queue_cmd(REQ_ENQUEUE, 16'($urandom), $urandom);
        queue_cmd(REQ_ACK, 16'h0001, $urandom);
        queue_cmd(REQ_ACK, 16'h0001, $urandom);
        queue_cmd(REQ_TICK, 16'($urandom), 32'd51);
        queue_cmd(REQ_TICK, 16'($urandom), 32'd100);
        queue_cmd(REQ_TICK, 16'($urandom), 32'hFFFF_FFF0);
        queue_cmd(REQ_ENQUEUE, 16'($urandom), $urandom);
        queue_cmd(REQ_TICK, 16'($urandom), 32'h0000_0040);
        queue_cmd(REQ_DATA, 16'h8000, $urandom);
        now_cursor = 32'h0000_0040;
        drain();

        program_regs(16'd30, 16'd150, 8'd2, 16'd10);
        random_items(60, 20);
        drain();

        // Zero timeouts: every sent slot goes out again on each tick, and the
        // retry counts run into saturation.
        idle_pct = 66;
        program_regs(16'd0, 16'd0, 8'hFF, 16'd0);
        repeat (SLOTS) queue_cmd(REQ_ENQUEUE, 16'($urandom), $urandom);
        repeat (260) queue_cmd(REQ_TICK, 16'($urandom), next_now(3));
        random_items(10, 3);
        drain();

        idle_pct = 0;
        program_regs(16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF);
        random_items(25, 40000);
        drain();

        program_regs(16'd1, 16'd1, 8'd1, 16'd1);
        random_items(15, 3);
        drain();

        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
